// File: src/ihex_pkg.sv
package ihex_pkg;

    localparam int RecordBytes  = 16;
    localparam int BufDepth     = 16;
    localparam int FillWidth    = $clog2(BufDepth + 1);
    localparam int IdxWidth     = $clog2(BufDepth);
    localparam int AddrWidth    = 16;

    localparam int ApbAddrWidth = 3;
    localparam int ApbDataWidth = 32;
    localparam int RegIdxWidth  = ApbAddrWidth - 2;

    localparam logic [RegIdxWidth-1:0] RegStartAddress = '0;
    localparam logic [AddrWidth-1:0]   StartAddrReset  = 16'h0100;

    localparam logic [7:0] RecordTypeData = 8'h00;
    localparam logic [7:0] CharColon      = 8'h3A;
    localparam logic [7:0] CharZero       = 8'h30;
    localparam logic [7:0] CharOne        = 8'h31;
    localparam logic [7:0] CharF          = 8'h46;
    localparam logic [7:0] CharCr         = 8'h0D;
    localparam logic [7:0] CharLf         = 8'h0A;
    localparam logic [7:0] CharAlphaBase  = 8'h37;

    localparam int EofIdxWidth = 4;
    localparam logic [EofIdxWidth-1:0] EofLastIdx = 4'd12;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       carries_byte;
        logic       end_of_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } out_item_t;

    typedef enum logic [2:0] {
        CK_COLON,
        CK_HEX,
        CK_CR,
        CK_LF,
        CK_EOF
    } char_kind_t;

    typedef enum logic [2:0] {
        BS_COUNT,
        BS_ADDR_HI,
        BS_ADDR_LO,
        BS_TYPE,
        BS_DATA,
        BS_CSUM
    } byte_sel_t;

    typedef struct packed {
        logic                   accept;
        logic                   emit;
        char_kind_t             kind;
        byte_sel_t              byte_sel;
        logic [IdxWidth-1:0]    idx;
        logic [EofIdxWidth-1:0] eof_idx;
        logic                   nib_lo;
        logic                   add_sum;
        logic                   rec_done;
        logic                   reload_addr;
        logic                   last;
    } dp_cmd_t;

    typedef struct packed {
        logic [FillWidth-1:0] fill;
    } dp_status_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] v8;
        v8 = {4'h0, v};
        return (v < 4'd10) ? (CharZero + v8) : (CharAlphaBase + v8);
    endfunction

    // ":00000001FF" CR LF
    function automatic logic [7:0] eof_record_char(input logic [EofIdxWidth-1:0] idx);
        logic [7:0] c;
        unique case (idx) inside
            4'd0:          c = CharColon;
            [4'd1:4'd7]:   c = CharZero;
            4'd8:          c = CharOne;
            [4'd9:4'd10]:  c = CharF;
            4'd11:         c = CharCr;
            4'd12:         c = CharLf;
            default:       c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: src/ihex_ctrl.sv
module ihex_ctrl #(
    parameter int RECORD_BYTES = ihex_pkg::RecordBytes
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 carries_byte,
    input  logic                 end_of_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ihex_pkg::dp_status_t status,
    output ihex_pkg::dp_cmd_t    cmd
);

    localparam int FW = ihex_pkg::FillWidth;
    localparam int IW = ihex_pkg::IdxWidth;
    localparam int EW = ihex_pkg::EofIdxWidth;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COLON,
        S_HDR,
        S_DATA,
        S_CSUM,
        S_CR,
        S_LF,
        S_EOF
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic            nib_reg, nib_next;
    logic            eof_pending_reg, eof_pending_next;
    logic [EW-1:0]   eof_idx_reg, eof_idx_next;
    logic            out_valid_reg, out_valid_next;

    logic            accept;
    logic            emit;
    logic [FW-1:0]   fill_after;
    logic            rec_start;
    logic            last_data;
    logic            eof_done;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign emit       = (state_reg != S_IDLE) && (!out_valid_reg || out_ready);
    assign fill_after = status.fill + FW'(carries_byte);
    assign rec_start  = (carries_byte && (fill_after >= FW'(RECORD_BYTES)))
                      || (end_of_data && (fill_after != '0));
    assign last_data  = ((FW'(idx_reg) + FW'(1)) == status.fill);
    assign eof_done   = (eof_idx_reg == ihex_pkg::EofLastIdx);
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        nib_next         = nib_reg;
        eof_pending_next = eof_pending_reg;
        eof_idx_next     = eof_idx_reg;

        cmd             = '0;
        cmd.accept      = accept;
        cmd.emit        = emit;
        cmd.kind        = ihex_pkg::CK_COLON;
        cmd.byte_sel    = ihex_pkg::BS_DATA;
        cmd.idx         = idx_reg;
        cmd.eof_idx     = eof_idx_reg;
        cmd.nib_lo      = nib_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    eof_pending_next = end_of_data;
                    idx_next         = '0;
                    nib_next         = 1'b0;
                    eof_idx_next     = '0;
                    if (rec_start)
                        state_next = S_COLON;
                    else if (end_of_data)
                        state_next = S_EOF;
                end
            end
            S_COLON:
            begin
                cmd.kind = ihex_pkg::CK_COLON;
                if (emit)
                    state_next = S_HDR;
            end
            S_HDR:
            begin
                cmd.kind = ihex_pkg::CK_HEX;
                unique case (idx_reg[1:0])
                    2'd0:    cmd.byte_sel = ihex_pkg::BS_COUNT;
                    2'd1:    cmd.byte_sel = ihex_pkg::BS_ADDR_HI;
                    2'd2:    cmd.byte_sel = ihex_pkg::BS_ADDR_LO;
                    default: cmd.byte_sel = ihex_pkg::BS_TYPE;
                endcase
                cmd.add_sum = emit && nib_reg;
                if (emit)
                begin
                    nib_next = !nib_reg;
                    if (nib_reg)
                    begin
                        if (idx_reg[1:0] == 2'd3)
                        begin
                            idx_next   = '0;
                            state_next = S_DATA;
                        end
                        else
                            idx_next = idx_reg + IW'(1);
                    end
                end
            end
            S_DATA:
            begin
                cmd.kind     = ihex_pkg::CK_HEX;
                cmd.byte_sel = ihex_pkg::BS_DATA;
                cmd.add_sum  = emit && nib_reg;
                if (emit)
                begin
                    nib_next = !nib_reg;
                    if (nib_reg)
                    begin
                        if (last_data)
                            state_next = S_CSUM;
                        else
                            idx_next = idx_reg + IW'(1);
                    end
                end
            end
            S_CSUM:
            begin
                cmd.kind     = ihex_pkg::CK_HEX;
                cmd.byte_sel = ihex_pkg::BS_CSUM;
                if (emit)
                begin
                    nib_next = !nib_reg;
                    if (nib_reg)
                        state_next = S_CR;
                end
            end
            S_CR:
            begin
                cmd.kind = ihex_pkg::CK_CR;
                if (emit)
                    state_next = S_LF;
            end
            S_LF:
            begin
                cmd.kind     = ihex_pkg::CK_LF;
                cmd.last     = !eof_pending_reg;
                cmd.rec_done = emit;
                if (emit)
                    state_next = eof_pending_reg ? S_EOF : S_IDLE;
            end
            S_EOF:
            begin
                cmd.kind        = ihex_pkg::CK_EOF;
                cmd.last        = eof_done;
                cmd.reload_addr = emit && eof_done;
                if (emit)
                begin
                    if (eof_done)
                        state_next = S_IDLE;
                    else
                        eof_idx_next = eof_idx_reg + EW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            nib_reg         <= 1'b0;
            eof_pending_reg <= 1'b0;
            eof_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            nib_reg         <= nib_next;
            eof_pending_reg <= eof_pending_next;
            eof_idx_reg     <= eof_idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

endmodule

// File: src/ihex_dp.sv
module ihex_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ihex_pkg::in_item_t                   in_item,
    input  ihex_pkg::dp_cmd_t                    cmd,
    output ihex_pkg::dp_status_t                 status,
    output ihex_pkg::out_item_t                  out_item,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ihex_pkg::ApbAddrWidth-1:0]    paddr,
    input  logic [ihex_pkg::ApbDataWidth-1:0]    pwdata,
    output logic [ihex_pkg::ApbDataWidth-1:0]    prdata
);

    localparam int FW = ihex_pkg::FillWidth;
    localparam int IW = ihex_pkg::IdxWidth;
    localparam int AW = ihex_pkg::AddrWidth;
    localparam int DW = ihex_pkg::ApbDataWidth;

    logic [7:0]    buf_reg [ihex_pkg::BufDepth];
    logic [FW-1:0] fill_reg, fill_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] start_reg;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    out_char_reg;
    logic          last_char_reg;

    logic          reg_hit;
    logic          cfg_write;
    logic [7:0]    cur_byte;
    logic [3:0]    nibble;
    logic [7:0]    char_next;

    assign reg_hit   = (paddr[ihex_pkg::ApbAddrWidth-1:2] == ihex_pkg::RegStartAddress);
    assign cfg_write = psel && penable && pwrite && reg_hit;
    assign prdata    = reg_hit ? {{(DW - AW){1'b0}}, start_reg} : '0;

    assign status.fill = fill_reg;

    always_comb
    begin
        case (cmd.byte_sel)
            ihex_pkg::BS_COUNT:   cur_byte = {{(8 - FW){1'b0}}, fill_reg};
            ihex_pkg::BS_ADDR_HI: cur_byte = addr_reg[15:8];
            ihex_pkg::BS_ADDR_LO: cur_byte = addr_reg[7:0];
            ihex_pkg::BS_TYPE:    cur_byte = ihex_pkg::RecordTypeData;
            ihex_pkg::BS_DATA:    cur_byte = buf_reg[cmd.idx];
            ihex_pkg::BS_CSUM:    cur_byte = 8'h00 - sum_reg;
            default:              cur_byte = 8'h00;
        endcase

        nibble = cmd.nib_lo ? cur_byte[3:0] : cur_byte[7:4];

        case (cmd.kind)
            ihex_pkg::CK_COLON: char_next = ihex_pkg::CharColon;
            ihex_pkg::CK_HEX:   char_next = ihex_pkg::hex_digit(nibble);
            ihex_pkg::CK_CR:    char_next = ihex_pkg::CharCr;
            ihex_pkg::CK_LF:    char_next = ihex_pkg::CharLf;
            ihex_pkg::CK_EOF:   char_next = ihex_pkg::eof_record_char(cmd.eof_idx);
            default:            char_next = 8'h00;
        endcase
    end

    always_comb
    begin
        fill_next = fill_reg;
        addr_next = addr_reg;
        sum_next  = sum_reg;
        if (cmd.accept)
        begin
            fill_next = fill_reg + FW'(in_item.carries_byte);
            sum_next  = 8'h00;
        end
        if (cmd.add_sum)
            sum_next = sum_reg + cur_byte;
        if (cmd.rec_done)
        begin
            fill_next = '0;
            addr_next = addr_reg + {{(AW - FW){1'b0}}, fill_reg};
        end
        if (cmd.reload_addr)
            addr_next = start_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            addr_reg  <= ihex_pkg::StartAddrReset;
            start_reg <= ihex_pkg::StartAddrReset;
        end
        else
        begin
            fill_reg <= fill_next;
            addr_reg <= addr_next;
            if (cfg_write)
                start_reg <= pwdata[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (cmd.accept && in_item.carries_byte && (fill_reg < FW'(ihex_pkg::BufDepth)))
            buf_reg[fill_reg[IW-1:0]] <= in_item.data_byte;
        if (cmd.emit)
        begin
            out_char_reg  <= char_next;
            last_char_reg <= cmd.last;
        end
    end

    assign out_item.out_char  = out_char_reg;
    assign out_item.last_char = last_char_reg;

endmodule

// File: src/intel_hex_record_encoder.sv
// Intel HEX record encoder.
// Input channel (in_valid/in_ready/in_item): one image byte per transfer, or a
// bare end marker. Output channel (out_valid/out_ready/out_item): one ASCII
// character per transfer, last_char set on the final character of an item.
// Bytes collect in a 16-entry buffer; a full buffer, or end_of_data with
// bytes pending, produces one data record (13 + 2*count characters), and
// end_of_data then adds the 13-character EOF record and reloads the load
// address from start_address (APB register at byte address 0).
// Timing: one character per cycle from the record sequencer while the
// receiver takes them. An item that only fills the buffer leaves in_ready
// high; a full record is 45 characters, the EOF record 13 more. The first
// character passes the state register and then the output register.
// The block works on one item at a time: in_ready is high only while the
// sequencer is idle, and the next item is taken while the last character
// still waits in the output register.
// A stalled receiver holds the output register and the sequencer stops.
// Reset empties the buffer, drops any pending output and sets both the load
// address and start_address to 0x0100.
module intel_hex_record_encoder #(
    parameter int RECORD_BYTES = ihex_pkg::RecordBytes
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ihex_pkg::in_item_t                in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ihex_pkg::out_item_t               out_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ihex_pkg::ApbAddrWidth-1:0] paddr,
    input  logic [ihex_pkg::ApbDataWidth-1:0] pwdata,
    output logic [ihex_pkg::ApbDataWidth-1:0] prdata,
    output logic                              pready
);

    ihex_pkg::dp_cmd_t    cmd;
    ihex_pkg::dp_status_t status;

    assign pready = 1'b1;

    ihex_ctrl #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .carries_byte (in_item.carries_byte),
        .end_of_data  (in_item.end_of_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .cmd          (cmd)
    );

    ihex_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_item),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata)
    );

endmodule

// File: src/ihex_chk.sv
module ihex_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input ihex_pkg::in_item_t                in_item,
    input logic                              out_valid,
    input logic                              out_ready,
    input ihex_pkg::out_item_t               out_item,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [ihex_pkg::ApbAddrWidth-1:0] paddr,
    input logic [ihex_pkg::ApbDataWidth-1:0] pwdata,
    input logic [ihex_pkg::ApbDataWidth-1:0] prdata,
    input logic                              pready
);

    // stalled output transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output changed while stalled");

    // every item's character run ends with a line feed
    a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.last_char |-> out_item.out_char == ihex_pkg::CharLf)
        else $error("final character is not LF");

    // an item still has characters to come, so no new item may be taken
    a_busy_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.last_char |-> !in_ready)
        else $error("input taken mid-record");

    // an item with neither byte nor end leaves the block ready
    a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_item.carries_byte && !in_item.end_of_data
        |=> in_ready)
        else $error("empty item made the block busy");

    // end of data always starts a record
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_item.end_of_data |=> !in_ready)
        else $error("end marker produced no record");

endmodule

bind intel_hex_record_encoder ihex_chk u_ihex_chk (.*);

// File: sim/tb_intel_hex_record_encoder.sv
`timescale 1ns / 100ps

module tb_intel_hex_record_encoder;
    import ihex_pkg::*;

    localparam int ResetCycles  = 9;
    localparam int SettleCycles = 8;
    localparam int HoldCycles   = 300;
    localparam int StallLimit   = 2000;
    localparam int RunLimit     = 200000;
    localparam int PhaseItems   = 32;
    localparam logic [RegIdxWidth-1:0] RegSpare = 1'b1;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    in_item_t                in_item;
    logic                    out_valid;
    logic                    out_ready;
    out_item_t               out_item;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ApbAddrWidth-1:0] paddr;
    logic [ApbDataWidth-1:0] pwdata;
    logic [ApbDataWidth-1:0] prdata;
    logic                    pready;

    intel_hex_record_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #2 clk = ~clk;

    // encoder shadow state
    logic [7:0]           image_bytes [BufDepth];
    logic [FillWidth-1:0] image_fill = '0;
    logic [AddrWidth-1:0] load_addr = StartAddrReset;
    logic [AddrWidth-1:0] start_addr_shadow = StartAddrReset;

    out_item_t hex_text[$];       // characters predicted for one input transfer
    out_item_t pending_chars[$];  // characters still owed by the block
    bit        typed_flag_q[$];
    string     typed_text_q[$];

    in_item_t  dir_item[$];
    bit        dir_typed[$];
    string     dir_text[$];

    string hex_digits = "0123456789ABCDEF";
    string eof_text   = ":00000001FF\015\012";

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asks      = 0;
    int hold_served    = 0;
    int errors         = 0;
    int idle_cycles    = 0;
    int run_cycles     = 0;
    int items_in       = 0;
    int chars_out      = 0;
    int records        = 0;

    function automatic void put_char(input logic [7:0] ch);
        out_item_t c;
        c.out_char  = ch;
        c.last_char = 1'b0;
        hex_text.push_back(c);
    endfunction

    function automatic void put_hex(input logic [7:0] b);
        put_char(hex_digits[b[7:4]]);
        put_char(hex_digits[b[3:0]]);
    endfunction

    function automatic void flush_record();
        logic [7:0] count;
        logic [7:0] sum;
        count = 8'(image_fill);
        sum = count + load_addr[15:8] + load_addr[7:0] + RecordTypeData;
        put_char(CharColon);
        put_hex(count);
        put_hex(load_addr[15:8]);
        put_hex(load_addr[7:0]);
        put_hex(RecordTypeData);
        for (int i = 0; i < int'(count); i++)
        begin
            sum = sum + image_bytes[i];
            put_hex(image_bytes[i]);
        end
        put_hex(8'h00 - sum);
        put_char(CharCr);
        put_char(CharLf);
        load_addr  = load_addr + {8'h00, count};
        image_fill = '0;
        records++;
    endfunction

    function automatic void encode_transfer(input in_item_t it);
        out_item_t tail;
        hex_text.delete();
        if (it.carries_byte)
        begin
            image_bytes[image_fill[IdxWidth-1:0]] = it.data_byte;
            image_fill = image_fill + 1'b1;
            if (image_fill >= RecordBytes)
                flush_record();
        end
        if (it.end_of_data)
        begin
            if (image_fill != 0)
                flush_record();
            for (int i = 0; i < eof_text.len(); i++)
                put_char(eof_text[i]);
            load_addr = start_addr_shadow;
        end
        if (hex_text.size() != 0)
        begin
            tail = hex_text.pop_back();
            tail.last_char = 1'b1;
            hex_text.push_back(tail);
        end
    endfunction

    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned r;
        r = $urandom_range(99);
        it.data_byte    = 8'($urandom_range(255));
        it.carries_byte = (r < 93);
        it.end_of_data  = (r >= 90 && r < 96);
        return it;
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic c, input logic e,
                                    input bit typed, input string text);
        dir_item.push_back(in_item_t'({b, c, e}));
        dir_typed.push_back(typed);
        dir_text.push_back(text);
    endfunction

    // checks on the rising edge; watchdog last so nothing follows its $finish
    always @(posedge clk)
    begin : scoreboard
        out_item_t want;
        string     text;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                items_in++;
                encode_transfer(in_item);
                text = typed_text_q.pop_front();
                if (typed_flag_q.pop_front())
                begin
                    for (int i = 0; i < text.len(); i++)
                    begin
                        want.out_char  = text[i];
                        want.last_char = (i == text.len() - 1);
                        pending_chars.push_back(want);
                    end
                end
                else
                begin
                    foreach (hex_text[i])
                        pending_chars.push_back(hex_text[i]);
                end
            end
            if (out_valid && out_ready)
            begin
                chars_out++;
                if (pending_chars.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected character: expected none, actual %h last %b",
                             $time, out_item.out_char, out_item.last_char);
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (out_item.out_char !== want.out_char)
                    begin
                        errors++;
                        $display("%0t: out_char mismatch: expected %h, actual %h",
                                 $time, want.out_char, out_item.out_char);
                    end
                    if (out_item.last_char !== want.last_char)
                    begin
                        errors++;
                        $display("%0t: last_char mismatch: expected %b, actual %b",
                                 $time, want.last_char, out_item.last_char);
                    end
                end
            end
        end
        run_cycles++;
        if (run_cycles >= RunLimit)
        begin
            $display("%0t: run exceeded %0d cycles", $time, RunLimit);
            $display("TEST FAILED");
            $finish;
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= StallLimit)
        begin
            $display("%0t: no transfer for %0d cycles", $time, StallLimit);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != hold_served)
            begin
                hold_served = hold_asks;
                out_ready <= 1'b0;
                repeat (HoldCycles) @(negedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(input in_item_t it, input bit typed, input string text);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        typed_flag_q.push_back(typed);
        typed_text_q.push_back(text);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    // write one register, then read start_address back
    task automatic write_reg(input logic [RegIdxWidth-1:0] idx,
                             input logic [ApbDataWidth-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (idx == RegStartAddress)
            start_addr_shadow = value[AddrWidth-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {RegStartAddress, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[AddrWidth-1:0] !== start_addr_shadow)
        begin
            errors++;
            $display("%0t: start_address readback: expected %h, actual %h",
                     $time, start_addr_shadow, prdata[AddrWidth-1:0]);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        in_item_t it;
        int       done;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < PhaseItems)
        begin
            it = random_item();
            if (it.carries_byte || it.end_of_data)
                done++;
            send_item(it, 1'b0, "");
        end
        settle();
    endtask

    initial
    begin : stimulus
        logic [3:0] nib;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (ResetCycles) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty end marker, idle item, one-byte images at the extremes,
        // a full record closed by byte-and-end, then a partial record flushed
        add_row(8'h00, 1'b0, 1'b1, 1'b1, eof_text);
        add_row(8'hFF, 1'b0, 1'b0, 1'b1, "");
        add_row(8'h00, 1'b1, 1'b1, 1'b1, {":0101000000FE\015\012", eof_text});
        add_row(8'hFF, 1'b1, 1'b1, 1'b1, {":01010000FFFF\015\012", eof_text});
        for (int i = 0; i < RecordBytes; i++)
        begin
            nib = i[3:0];
            add_row({nib, ~nib}, 1'b1, (i == RecordBytes - 1), 1'b0, "");
        end
        add_row(8'h80, 1'b1, 1'b0, 1'b0, "");
        add_row(8'h01, 1'b1, 1'b0, 1'b0, "");
        add_row(8'h5A, 1'b0, 1'b0, 1'b0, "");
        add_row(8'h00, 1'b0, 1'b1, 1'b0, "");
        foreach (dir_item[k])
            send_item(dir_item[k], dir_typed[k], dir_text[k]);
        settle();

        write_reg(RegStartAddress, 32'h0000_0000);
        write_reg(RegSpare, $urandom);
        run_phase(0, 0);

        write_reg(RegStartAddress, 32'h0000_FFFF);
        run_phase(51, 0);

        // near the top so records wrap; long receiver hold-off at the start
        write_reg(RegStartAddress, 32'h0000_FFF8);
        hold_asks++;
        run_phase(0, 51);

        write_reg(RegStartAddress, ApbDataWidth'($urandom_range(65535)));
        run_phase(32, 32);

        settle();
        $display("Ran %0d input transfers, %0d output characters, %0d data records",
                 items_in, chars_out, records);
        $display("over four idling mixes, one long stall and five load addresses; %0d errors",
                 errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
src/ihex_pkg.sv
src/ihex_ctrl.sv
src/ihex_dp.sv
src/intel_hex_record_encoder.sv
src/ihex_chk.sv
sim/tb_intel_hex_record_encoder.sv
